// ===== rtl/vst_pkg.sv =====
package vst_pkg;

  localparam int SpriteSlotsDefault = 8;
  localparam int SpriteCountDefault = 64;

  localparam logic [3:0] CMD_TICK     = 4'd0;
  localparam logic [3:0] CMD_CTRL     = 4'd1;
  localparam logic [3:0] CMD_MASK     = 4'd2;
  localparam logic [3:0] CMD_STATUS   = 4'd3;
  localparam logic [3:0] CMD_OAMADDR  = 4'd4;
  localparam logic [3:0] CMD_OAMWR    = 4'd5;
  localparam logic [3:0] CMD_OAMRD    = 4'd6;
  localparam logic [3:0] CMD_SCROLL   = 4'd7;
  localparam logic [3:0] CMD_ADDR     = 4'd8;
  localparam logic [3:0] CMD_DATAWR   = 4'd9;
  localparam logic [3:0] CMD_DATARD   = 4'd10;

  localparam logic [8:0] DOT_LAST     = 9'd340;
  localparam logic [8:0] LINE_LAST    = 9'd261;

  typedef struct packed {
    logic [3:0] cmd;
    logic [7:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [14:0] vram_addr;
    logic        vram_write;
    logic        vram_read;
    logic [7:0]  vram_wdata;
    logic        nmi_pulse;
    logic        vblank_flag;
    logic        overflow_flag;
    logic [8:0]  line_now;
    logic [8:0]  dot_now;
    logic        odd_frame;
  } out_beat_t;

  // Controller to datapath.
  typedef struct packed {
    logic       exec;       // apply the held item to the registers
    logic       eval_start; // begin the sprite scan
    logic       eval_step;  // one OAM y byte is on the read port
    logic       eval_done;  // write overflow and count
    logic       load_out;   // capture the result beat
    logic [7:0] oam_raddr;
  } vst_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_eval;  // held tick lands on dot 340 of a visible line
    logic scan_stop;  // overflow already found
  } vst_stat_t;

endpackage

// ===== rtl/vst_if.sv =====
interface vst_in_if;
  import vst_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vst_out_if;
  import vst_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/vst_ram.sv =====
module vst_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/vst_ctrl.sv =====
module vst_ctrl #(
  parameter int SpriteCount = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  vst_pkg::vst_stat_t stat,
  output vst_pkg::vst_cmd_t  cmd
);
  import vst_pkg::*;

  localparam int CntW = $clog2(SpriteCount + 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DEC   = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_EXEC  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]      state;
  logic [2:0]      state_next;
  logic [7:0]      clr;
  logic [CntW-1:0] idx;
  logic            rd_pend;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.oam_raddr  = 8'(idx) << 2;
    unique case (state)
      ST_CLEAR: begin
        if (clr == 8'd255) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DEC;
        end
      end
      ST_DEC: begin
        if (stat.need_eval) begin
          cmd.eval_start = 1'b1;
          state_next     = ST_SCAN;
        end else begin
          state_next = ST_EXEC;
        end
      end
      ST_SCAN: begin
        cmd.eval_step = rd_pend;
        if (stat.scan_stop) begin
          cmd.eval_done = 1'b1;
          state_next    = ST_EXEC;
        end else if (rd_pend && idx == CntW'(SpriteCount)) begin
          // The last y byte is counted in this cycle; its result is ready next cycle.
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.eval_done = 1'b1;
        state_next    = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec     = 1'b1;
        cmd.load_out = 1'b1;
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr     <= '0;
      idx     <= '0;
      rd_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr <= clr + 8'd1;
      end
      if (state == ST_DEC) begin
        idx     <= '0;
        rd_pend <= 1'b0;
      end else if (state == ST_SCAN) begin
        // Address idx is issued now; its data appears next cycle.
        if (idx != CntW'(SpriteCount)) begin
          idx <= idx + CntW'(1);
        end
        rd_pend <= 1'b1;
      end
    end
  end
endmodule

// ===== rtl/vst_dp.sv =====
module vst_dp #(
  parameter int SpriteSlots = 8,
  parameter int SpriteCount = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  vst_pkg::in_beat_t  in_data,
  input  vst_pkg::vst_cmd_t  cmd,
  output vst_pkg::vst_stat_t stat,
  output vst_pkg::out_beat_t out_data
);
  import vst_pkg::*;

  localparam int HitW = $clog2(SpriteCount + 1) + 1;

  logic [3:0]  hcmd;
  logic [7:0]  hval;
  logic [7:0]  ctrl_bits, mask_bits, oam_address;
  logic        vblank, overflow, first_write, frame_even;
  logic [2:0]  fine_x;
  logic [14:0] temp_address, scroll_address, sa;
  logic [8:0]  line_count, dot_count;
  logic [3:0]  sprites_on_line;
  logic [HitW-1:0] hits;
  logic        over;
  logic        clearing;
  logic [7:0]  clr_addr;
  out_beat_t   res, res_next;

  // OAM store.
  logic       ram_we;
  logic [7:0] ram_waddr, ram_wdata, ram_rdata, ram_raddr;

  assign ram_we    = clearing || (cmd.exec && hcmd == CMD_OAMWR);
  assign ram_waddr = clearing ? clr_addr : oam_address;
  assign ram_wdata = clearing ? 8'd0 : hval;
  assign ram_raddr = (hcmd == CMD_OAMRD) ? oam_address : cmd.oam_raddr;

  vst_ram #(.Width(8), .Depth(256)) u_oam (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic both_on, bg_on, vis;
  assign bg_on   = mask_bits[3];
  assign both_on = mask_bits[3] && mask_bits[4];
  assign vis     = line_count != 9'd0 && line_count <= 9'd240;

  assign stat = '{
    need_eval: hcmd == CMD_TICK && vis && dot_count == DOT_LAST,
    scan_stop: over
  };

  // Sprite y test: y in (scanline - height, scanline].
  logic [9:0] sl, yd;
  logic       hit;
  assign sl  = {1'b0, line_count} - 10'd1;
  assign yd  = sl - {2'b0, ram_rdata};
  assign hit = !yd[9] && (yd < (ctrl_bits[5] ? 10'd16 : 10'd8));

  logic [14:0] inc;
  assign inc = ctrl_bits[2] ? 15'd32 : 15'd1;

  logic [2:0] xs;
  assign xs = 3'(dot_count - 9'd1) + fine_x;

  // Tick update of the scroll address.
  always_comb begin
    logic [2:0] fy;
    logic [4:0] cy;
    sa = scroll_address;
    fy = sa[14:12];
    cy = sa[9:5];
    if (line_count == 9'd0) begin
      if (dot_count == 9'd258 && both_on)
        sa = {sa[14:11], temp_address[10], sa[9:5], temp_address[4:0]};
      if (dot_count >= 9'd280 && dot_count <= 9'd304 && both_on)
        sa = {temp_address[14:11], sa[10], temp_address[9:5], sa[4:0]};
    end else if (vis) begin
      if (dot_count >= 9'd1 && dot_count <= 9'd256 && bg_on && xs == 3'd7) begin
        if (sa[4:0] == 5'd31) begin
          sa[4:0] = 5'd0;
          sa[10]  = ~sa[10];
        end else begin
          sa[4:0] = sa[4:0] + 5'd1;
        end
      end
      if (dot_count == 9'd257 && bg_on) begin
        if (fy != 3'd7) begin
          sa[14:12] = fy + 3'd1;
        end else begin
          sa[14:12] = 3'd0;
          if (cy == 5'd29) begin
            cy     = 5'd0;
            sa[11] = ~sa[11];
          end else if (cy == 5'd31) begin
            cy = 5'd0;
          end else begin
            cy = cy + 5'd1;
          end
          sa[9:5] = cy;
        end
      end
      if (dot_count == 9'd258 && both_on)
        sa = {sa[14:11], temp_address[10], sa[9:5], temp_address[4:0]};
    end
  end

  // Per-item result fields, taken from the registers before the item is applied.
  always_comb begin
    res_next = '0;
    unique case (hcmd)
      CMD_TICK: res_next.nmi_pulse = line_count == 9'd242 && dot_count == 9'd1 && ctrl_bits[7];
      CMD_STATUS: res_next.read_data = {vblank, 1'b0, overflow, 5'd0};
      CMD_OAMRD: res_next.read_data = ram_rdata;
      CMD_DATAWR: begin
        res_next.vram_addr  = scroll_address;
        res_next.vram_write = 1'b1;
        res_next.vram_wdata = hval;
      end
      CMD_DATARD: begin
        res_next.vram_addr = scroll_address;
        res_next.vram_read = 1'b1;
      end
      default: ;
    endcase
  end

  // Flags, position and frame come from the registers, which hold still
  // while the result waits.
  assign out_data = '{
    read_data:     res.read_data,
    vram_addr:     res.vram_addr,
    vram_write:    res.vram_write,
    vram_read:     res.vram_read,
    vram_wdata:    res.vram_wdata,
    nmi_pulse:     res.nmi_pulse,
    vblank_flag:   vblank,
    overflow_flag: overflow,
    line_now:      line_count,
    dot_now:       dot_count,
    odd_frame:     ~frame_even
  };

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hcmd <= in_data.cmd;
      hval <= in_data.value;
    end
    if (cmd.eval_start) begin
      hits <= '0;
      over <= 1'b0;
    end else if (cmd.eval_step && !over && hit) begin
      if (hits >= HitW'(SpriteSlots)) over <= 1'b1;
      else hits <= hits + HitW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_bits <= '0; mask_bits <= '0; vblank <= 1'b0; overflow <= 1'b0;
      first_write <= 1'b1; fine_x <= '0; temp_address <= '0; scroll_address <= '0;
      line_count <= '0; dot_count <= '0; frame_even <= 1'b1; oam_address <= '0;
      sprites_on_line <= '0; clearing <= 1'b1; clr_addr <= '0;
      res <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 8'd1;
        if (clr_addr == 8'd255) clearing <= 1'b0;
      end
      if (cmd.eval_done) begin
        overflow        <= over;
        sprites_on_line <= (hits > HitW'(15)) ? 4'd15 : 4'(hits);
      end
      if (cmd.load_out) begin
        res <= res_next;
      end
      if (cmd.exec) begin
        unique case (hcmd)
          CMD_TICK: begin
            scroll_address <= sa;
            if (line_count == 9'd0 && dot_count == 9'd1) begin
              vblank <= 1'b0; overflow <= 1'b0;
            end
            if (line_count == 9'd242 && dot_count == 9'd1) begin
              vblank <= 1'b1;
            end
            if (line_count == 9'd0 &&
                dot_count >= (DOT_LAST - 9'((!frame_even && both_on) ? 1 : 0))) begin
              dot_count <= '0; line_count <= 9'd1;
            end else if (dot_count >= DOT_LAST) begin
              dot_count <= '0;
              if (line_count >= LINE_LAST) begin
                line_count <= '0; frame_even <= ~frame_even;
              end else begin
                line_count <= line_count + 9'd1;
              end
            end else begin
              dot_count <= dot_count + 9'd1;
            end
          end
          CMD_CTRL: begin
            ctrl_bits <= hval; temp_address[11:10] <= hval[1:0];
          end
          CMD_MASK: mask_bits <= hval;
          CMD_STATUS: begin
            vblank <= 1'b0; first_write <= 1'b1;
          end
          CMD_OAMADDR: oam_address <= hval;
          CMD_OAMWR: oam_address <= oam_address + 8'd1;
          CMD_SCROLL: begin
            if (first_write) begin
              temp_address[4:0] <= hval[7:3]; fine_x <= hval[2:0];
            end else begin
              temp_address <= {hval[2:0], temp_address[11:10], hval[7:3], temp_address[4:0]};
            end
            first_write <= ~first_write;
          end
          CMD_ADDR: begin
            if (first_write) begin
              temp_address[14:8] <= {1'b0, hval[5:0]};
            end else begin
              temp_address[7:0] <= hval;
              scroll_address    <= {temp_address[14:8], hval};
            end
            first_write <= ~first_write;
          end
          CMD_DATAWR: scroll_address <= scroll_address + inc;
          CMD_DATARD: scroll_address <= scroll_address + inc;
          default: ;
        endcase
      end
    end
  end

  logic unused_sol;
  assign unused_sol = ^sprites_on_line;
endmodule

// ===== rtl/video_scroll_timing_unit.sv =====
// Video scroll and timing unit. Each input beat is a dot tick or one CPU
// register access and yields exactly one result beat. The unit works on one
// item at a time: an item passes through the accepting cycle, a decode cycle,
// an execute cycle and the output cycle in which the result beat is offered,
// and the next item can be accepted in the cycle after the result beat is
// taken. A stalled result keeps the unit in the output cycle. The tick at dot
// 340 of a visible line also scans the OAM y bytes one per cycle through the
// OAM memory's single read port, and the scan stops early once overflow is
// found. After reset the OAM memory is cleared by a pass over all 256
// addresses during which no item is accepted. The result's flags, line, dot
// and frame fields come straight from the registers, which do not change
// while the result waits.
module video_scroll_timing_unit #(
  parameter int SpriteSlots = vst_pkg::SpriteSlotsDefault,
  parameter int SpriteCount = vst_pkg::SpriteCountDefault
) (
  input logic       clk,
  input logic       rst,
  vst_in_if.sink    in_ch,
  vst_out_if.source out_ch
);
  import vst_pkg::*;

  vst_cmd_t  cmd;
  vst_stat_t stat;
  logic      in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;

  vst_ctrl #(.SpriteCount(SpriteCount)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  vst_dp #(.SpriteSlots(SpriteSlots), .SpriteCount(SpriteCount)) u_dp (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_data(in_ch.data),
    .cmd(cmd), .stat(stat), .out_data(out_ch.data)
  );

  // A result never coexists with a waiting input acceptance.
  assert property (@(posedge clk) disable iff (rst) !(in_ch.ready && out_ch.valid))
    else $error("ready while result pending");

  // A delivered result is followed by readiness for the next item.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready |=> in_ch.ready)
    else $error("no return to idle");

  // The dot counter never passes the last dot.
  assert property (@(posedge clk) disable iff (rst) out_ch.valid |-> out_ch.data.dot_now <= 9'd340)
    else $error("dot out of range");
endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vst_pkg::*;

  // The unit runs a dot clock through 262 lines of 341 dots. The random part
  // is mostly ticks in short bursts, enough to leave the prerender line and
  // step the scroll address into the first visible line, mixed with register
  // traffic that moves the scroll state.

  localparam int CycleLimit = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  vst_in_if  in_ch ();
  vst_out_if out_ch ();

  video_scroll_timing_unit u_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Shadow copy of the unit's registers, used to predict every result beat.
  logic [7:0]  sh_ctrl, sh_mask, sh_oam_addr;
  logic        sh_vblank, sh_over, sh_first, sh_even;
  logic [2:0]  sh_fine_x;
  logic [14:0] sh_temp, sh_vaddr;
  logic [8:0]  sh_line, sh_dot;
  logic [7:0]  sh_oam [256];

  out_beat_t expected_beats[$];
  int        fail_count = 0;
  int        beats_seen = 0;
  int        nmi_seen = 0;
  int        over_seen = 0;
  longint    cycle = 0;

  function automatic logic show_on();
    return sh_mask[3] && sh_mask[4];
  endfunction

  function automatic void copy_horiz();
    sh_vaddr = (sh_vaddr & ~15'h041f) | (sh_temp & 15'h041f);
  endfunction

  function automatic void copy_vert();
    sh_vaddr = (sh_vaddr & ~15'h7be0) | (sh_temp & 15'h7be0);
  endfunction

  function automatic void step_x();
    if (sh_vaddr[4:0] == 5'd31) begin
      sh_vaddr[4:0] = 5'd0;
      sh_vaddr[10] = ~sh_vaddr[10];
    end else begin
      sh_vaddr[4:0] = sh_vaddr[4:0] + 5'd1;
    end
  endfunction

  function automatic void step_fine_y();
    if (sh_vaddr[14:12] != 3'd7) begin
      sh_vaddr[14:12] = sh_vaddr[14:12] + 3'd1;
    end else begin
      sh_vaddr[14:12] = 3'd0;
      if (sh_vaddr[9:5] == 5'd29) begin
        sh_vaddr[9:5] = 5'd0;
        sh_vaddr[11] = ~sh_vaddr[11];
      end else if (sh_vaddr[9:5] == 5'd31) begin
        sh_vaddr[9:5] = 5'd0;
      end else begin
        sh_vaddr[9:5] = sh_vaddr[9:5] + 5'd1;
      end
    end
  endfunction

  // Counts sprites whose top row lies within height rows above the scanline.
  function automatic void scan_sprites(int scanline);
    int height, hits, yy;
    height = sh_ctrl[5] ? 16 : 8;
    hits = 0;
    sh_over = 1'b0;
    for (int i = 0; i < SpriteCountDefault; i++) begin
      yy = sh_oam[i * 4];
      if (yy > scanline - height && yy <= scanline) begin
        if (hits >= SpriteSlotsDefault) begin
          sh_over = 1'b1;
          break;
        end
        hits++;
      end
    end
  endfunction

  function automatic logic advance_dot();
    logic nmi;
    int   d, l;
    nmi = 1'b0;
    d = sh_dot;
    l = sh_line;
    if (l == 0) begin
      if (d == 1) begin
        sh_vblank = 1'b0;
        sh_over = 1'b0;
      end
      if (d == 258 && show_on()) copy_horiz();
      if (d >= 280 && d <= 304 && show_on()) copy_vert();
    end else if (l <= 240) begin
      if (d >= 1 && d <= 256 && sh_mask[3] && ((d - 1 + sh_fine_x) % 8) == 7) step_x();
      if (d == 257 && sh_mask[3]) step_fine_y();
      if (d == 258 && show_on()) copy_horiz();
      if (d == 340) scan_sprites(l - 1);
    end else if (l == 242 && d == 1) begin
      sh_vblank = 1'b1;
      nmi = sh_ctrl[7];
    end
    // The prerender line is one dot short on odd frames with rendering on.
    if (l == 0 && d >= (340 - ((!sh_even && show_on()) ? 1 : 0))) begin
      d = 0;
      l = 1;
    end else begin
      d++;
      if (d >= 341) begin
        d = 0;
        l++;
        if (l >= 262) begin
          sh_even = ~sh_even;
          l = 0;
        end
      end
    end
    sh_dot = d[8:0];
    sh_line = l[8:0];
    return nmi;
  endfunction

  function automatic out_beat_t predict_beat(in_beat_t b);
    out_beat_t r;
    logic [14:0] step;
    r = '0;
    step = sh_ctrl[2] ? 15'd32 : 15'd1;
    case (b.cmd)
      CMD_TICK: r.nmi_pulse = advance_dot();
      CMD_CTRL: begin
        sh_ctrl = b.value;
        sh_temp[11:10] = b.value[1:0];
      end
      CMD_MASK: sh_mask = b.value;
      CMD_STATUS: begin
        r.read_data = {sh_vblank, 1'b0, sh_over, 5'd0};
        sh_vblank = 1'b0;
        sh_first = 1'b1;
      end
      CMD_OAMADDR: sh_oam_addr = b.value;
      CMD_OAMWR: begin
        sh_oam[sh_oam_addr] = b.value;
        sh_oam_addr = sh_oam_addr + 8'd1;
      end
      CMD_OAMRD: r.read_data = sh_oam[sh_oam_addr];
      CMD_SCROLL: begin
        if (sh_first) begin
          sh_temp[4:0] = b.value[7:3];
          sh_fine_x = b.value[2:0];
        end else begin
          sh_temp = (sh_temp & 15'h0c1f) | (15'(b.value[7:3]) << 5) | (15'(b.value[2:0]) << 12);
        end
        sh_first = ~sh_first;
      end
      CMD_ADDR: begin
        if (sh_first) begin
          sh_temp = (sh_temp & 15'h00ff) | (15'(b.value[5:0]) << 8);
        end else begin
          sh_temp[7:0] = b.value;
          sh_vaddr = sh_temp;
        end
        sh_first = ~sh_first;
      end
      CMD_DATAWR, CMD_DATARD: begin
        r.vram_addr = sh_vaddr;
        r.vram_write = (b.cmd == CMD_DATAWR);
        r.vram_read = (b.cmd == CMD_DATARD);
        if (b.cmd == CMD_DATAWR) r.vram_wdata = b.value;
        sh_vaddr = sh_vaddr + step;
      end
      default: ;
    endcase
    r.vblank_flag = sh_vblank;
    r.overflow_flag = sh_over;
    r.line_now = sh_line;
    r.dot_now = sh_dot;
    r.odd_frame = ~sh_even;
    return r;
  endfunction

  // Sender: the beat is driven at the falling edge and held until taken.
  task automatic send_beat(logic [3:0] c, logic [7:0] v);
    in_ch.data <= '{cmd: c, value: v};
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_beats.push_back(predict_beat('{cmd: c, value: v}));
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Waits for the store of expected beats to drain, then idles with the
  // sprite scan latency on top.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // Receiver stalls on its own pattern: runs of random stalls, runs of free flow.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if ((stall_phase / 64) % 3 == 0) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  // Checker: compares every taken result beat against the oldest prediction.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst && out_ch.valid && out_ch.ready) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat %p", $realtime, out_ch.data);
        fail_count++;
      end else begin
        automatic out_beat_t want = expected_beats.pop_front();
        if (out_ch.data.nmi_pulse) nmi_seen++;
        if (out_ch.data.overflow_flag) over_seen++;
        if (out_ch.data !== want) begin
          $display("%0t: expected %p", $realtime, want);
          $display("%0t: actual   %p", $realtime, out_ch.data);
          fail_count++;
        end
      end
    end
    if (cycle > CycleLimit) begin
      $display("video_scroll_timing_unit: mismatch");
      $finish;
    end
  end

  // Directed rows. A row with has_rd set carries a literal read_data
  // expectation used on top of the predictor.
  typedef struct {
    logic [3:0] cmd;
    logic [7:0] value;
    logic       has_rd;
    logic [7:0] rd;
  } row_t;

  row_t directed[] = '{
    '{CMD_STATUS, 8'h00, 1'b1, 8'h00},   // status after reset is clear
    '{CMD_OAMRD, 8'hff, 1'b1, 8'h00},    // OAM reads zero after reset
    '{CMD_TICK, 8'h00, 1'b0, 8'h00},
    '{CMD_OAMADDR, 8'hff, 1'b0, 8'h00},
    '{CMD_OAMWR, 8'hff, 1'b0, 8'h00},    // wraps the OAM address to zero
    '{CMD_OAMRD, 8'h00, 1'b0, 8'h00},
    '{CMD_OAMADDR, 8'hff, 1'b0, 8'h00},
    '{CMD_OAMRD, 8'h00, 1'b1, 8'hff},
    '{CMD_CTRL, 8'hff, 1'b0, 8'h00},
    '{CMD_CTRL, 8'h00, 1'b0, 8'h00},
    '{CMD_MASK, 8'hff, 1'b0, 8'h00},
    '{CMD_SCROLL, 8'hff, 1'b0, 8'h00},
    '{CMD_SCROLL, 8'hff, 1'b0, 8'h00},
    '{CMD_ADDR, 8'hff, 1'b0, 8'h00},     // high write drops bit 14
    '{CMD_ADDR, 8'hff, 1'b0, 8'h00},
    '{CMD_DATAWR, 8'hff, 1'b0, 8'h00},   // address carries into bit 14
    '{CMD_DATARD, 8'h55, 1'b1, 8'h00},   // read buffer is not modelled
    '{CMD_CTRL, 8'h04, 1'b0, 8'h00},
    '{CMD_DATAWR, 8'h00, 1'b0, 8'h00},
    '{CMD_DATARD, 8'h00, 1'b0, 8'h00},
    '{4'd11, 8'hff, 1'b1, 8'h00},        // unused codes change nothing
    '{4'd15, 8'h00, 1'b1, 8'h00},
    '{CMD_MASK, 8'h00, 1'b0, 8'h00},
    '{CMD_ADDR, 8'h00, 1'b0, 8'h00},     // leaves the latch half way
    '{CMD_STATUS, 8'h00, 1'b0, 8'h00}    // status read resets the latch
  };

  task automatic random_access();
    logic [3:0] c;
    logic [7:0] v;
    c = 4'($urandom_range(1, 15));
    v = 8'($urandom);
    // Half the time an OAM write lands in 20 to 40, high on screen, so sprites pile up.
    if (c == CMD_OAMWR && $urandom_range(0, 1)) v = 8'($urandom_range(20, 40));
    if (c == CMD_MASK && $urandom_range(0, 2) != 0) v = v | 8'h18;
    send_beat(c, v);
  endtask

  int random_items;
  bit drained;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    sh_ctrl = '0; sh_mask = '0; sh_oam_addr = '0;
    sh_vblank = 1'b0; sh_over = 1'b0; sh_first = 1'b1; sh_even = 1'b1;
    sh_fine_x = '0; sh_temp = '0; sh_vaddr = '0; sh_line = '0; sh_dot = '0;
    foreach (sh_oam[i]) sh_oam[i] = 8'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      send_beat(directed[i].cmd, directed[i].value);
      if (directed[i].has_rd && expected_beats[$].read_data !== directed[i].rd) begin
        $display("%0t: expected read_data %h, predictor %h", $realtime,
                 directed[i].rd, expected_beats[$].read_data);
        fail_count++;
      end
    end
    drain();

    send_beat(CMD_CTRL, 8'h80);
    send_beat(CMD_MASK, 8'h18);

    // Random part: tick bursts that walk the prerender line and on into the
    // first visible line, with register accesses sprinkled in.
    random_items = 0;
    drained = 1'b0;
    while (random_items < 670) begin
      if ($urandom_range(0, 9) < 7) begin
        random_access();
        random_items++;
      end else begin
        automatic int burst = $urandom_range(5, 40);
        for (int k = 0; k < burst; k++) begin
          send_beat(CMD_TICK, 8'($urandom));
          if (k % 7 == 6 && $urandom_range(0, 1)) idle_gap($urandom_range(1, 5));
        end
        random_items += burst;
      end
      if (!drained && random_items >= 335) begin
        drained = 1'b1;
        drain();
      end else if ($urandom_range(0, 3) == 0) begin
        idle_gap($urandom_range(1, 6));
      end
    end
    drain();

    $display("Covered %0d result beats, %0d NMI pulses, %0d beats with sprite overflow.",
             beats_seen, nmi_seen, over_seen);
    if (fail_count == 0) begin
      $display("video_scroll_timing_unit: match");
    end else begin
      $display("video_scroll_timing_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/vst_pkg.sv
rtl/vst_if.sv
rtl/vst_ram.sv
rtl/vst_ctrl.sv
rtl/vst_dp.sv
rtl/video_scroll_timing_unit.sv
bench/testbench.sv
